/* src/mse_pkg.sv */
// shared types, opcode constants and decode helpers for the execute unit
`default_nettype none

package mse_pkg;

    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_J       = 6'h02;
    localparam logic [5:0] OPC_ADDIU   = 6'h09;
    localparam logic [5:0] OPC_ORI     = 6'h0D;
    localparam logic [5:0] OPC_LUI     = 6'h0F;
    localparam logic [5:0] OPC_SW      = 6'h2B;
    localparam logic [5:0] FN_SLL      = 6'h00;
    localparam logic [5:0] FN_OR       = 6'h25;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_UNIMPL   = 2'd1;
    localparam logic [1:0] ST_RESERVED = 2'd2;
    localparam logic [1:0] ST_BADFUNC  = 2'd3;

    // bit n set when opcode n is reserved
    localparam logic [63:0] RESERVED_MASK = 64'hF0F0_B080_FFF0_0000;

    localparam int DEC_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;

    typedef enum logic [2:0] {
        OP_LUI,
        OP_ORI,
        OP_ADD_IMM,
        OP_SW,
        OP_J,
        OP_SLL,
        OP_OR,
        OP_FAULT
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [1:0]         status;
        logic [REG_AW-1:0]  rs;
        logic [REG_AW-1:0]  rt;
        logic [REG_AW-1:0]  dst;
        logic [15:0]        imm;
        logic [4:0]         shamt;
        logic [31:0]        jump_target;
    } t_dec;

    typedef struct packed {
        logic [1:0]  status;
        logic        jump_taken;
        logic [31:0] jump_target;
        logic        store_valid;
        logic [31:0] store_address;
        logic [31:0] store_data;
    } t_res;

    function automatic logic op_writes_reg(input t_op op);
        return (op == OP_LUI) || (op == OP_ORI) || (op == OP_ADD_IMM) ||
               (op == OP_SLL) || (op == OP_OR);
    endfunction

endpackage

`default_nettype wire

/* src/mse_queue.sv */
// small first-in first-out queue built from flip-flops
`default_nettype none

module mse_queue
    import mse_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DEC_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

/* src/mse_front.sv */
// front end: instruction decode and fault classification
`default_nettype none

module mse_front
    import mse_pkg::*;
(
    input  wire logic [31:0] i_instruction_word,
    input  wire logic [31:0] i_current_pc,
    output t_dec             o_dec
);

    logic [5:0] opc;
    logic [5:0] func;

    assign opc  = i_instruction_word[31:26];
    assign func = i_instruction_word[5:0];

    always_comb begin
        o_dec             = '0;
        o_dec.op          = OP_FAULT;
        o_dec.status      = ST_DONE;
        o_dec.rs          = i_instruction_word[25:21];
        o_dec.rt          = i_instruction_word[20:16];
        o_dec.dst         = i_instruction_word[20:16];
        o_dec.imm         = i_instruction_word[15:0];
        o_dec.shamt       = i_instruction_word[10:6];
        o_dec.jump_target = '0;
        unique case (opc)
            OPC_LUI:   o_dec.op = OP_LUI;
            OPC_ORI:   o_dec.op = OP_ORI;
            OPC_ADDIU: o_dec.op = OP_ADD_IMM;
            OPC_SW:    o_dec.op = OP_SW;
            OPC_J: begin
                o_dec.op          = OP_J;
                o_dec.jump_target = {i_current_pc[31:28], i_instruction_word[25:0], 2'b00};
            end
            OPC_SPECIAL: begin
                o_dec.dst = i_instruction_word[15:11];
                if (func == FN_SLL) begin
                    o_dec.op = OP_SLL;
                end else if (func == FN_OR) begin
                    o_dec.op = OP_OR;
                end else begin
                    o_dec.status = ST_BADFUNC;
                end
            end
            default: begin
                o_dec.status = RESERVED_MASK[opc] ? ST_RESERVED : ST_UNIMPL;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/mse_back.sv */
// back end: register file read, execute and write back
`default_nettype none

module mse_back
    import mse_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_dec i_dec,
    input  wire logic i_dec_empty,
    output logic      o_dec_pop,
    output t_res      o_res,
    output logic      o_res_push,
    input  wire logic i_res_full
);

    logic [31:0]          r_regs [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;

    logic        r_ex_vld;
    t_dec        r_ex;
    logic [31:0] r_rd_a, r_rd_b;
    logic        r_hit_a, r_hit_b;
    logic        r_fwd_a, r_fwd_b;
    logic [31:0] r_fwd_data;

    logic        advance;
    logic        load;
    logic [31:0] val_a, val_b;
    logic [31:0] sext_imm;
    logic [31:0] wr_data;
    logic        wr_en;
    logic [REG_AW-1:0] wr_addr;

    assign advance   = r_ex_vld && !i_res_full;
    assign load      = !r_ex_vld || advance;
    assign o_dec_pop = load && !i_dec_empty;

    // operand select: same-cycle write bypass, then stored word, else reset zero
    assign val_a = r_fwd_a ? r_fwd_data : (r_hit_a ? r_rd_a : '0);
    assign val_b = r_fwd_b ? r_fwd_data : (r_hit_b ? r_rd_b : '0);
    assign sext_imm = {{16{r_ex.imm[15]}}, r_ex.imm};

    always_comb begin
        unique case (r_ex.op)
            OP_LUI:     wr_data = {r_ex.imm, 16'h0000};
            OP_ORI:     wr_data = val_a | {16'h0000, r_ex.imm};
            OP_ADD_IMM: wr_data = val_a + sext_imm;
            OP_SLL:     wr_data = val_b << r_ex.shamt;
            OP_OR:      wr_data = val_a | val_b;
            default:    wr_data = '0;
        endcase
    end

    assign wr_addr = r_ex.dst;
    assign wr_en   = advance && op_writes_reg(r_ex.op) && (r_ex.dst != '0);

    always_comb begin
        o_res             = '0;
        o_res.status      = r_ex.status;
        o_res.jump_taken  = (r_ex.op == OP_J);
        o_res.jump_target = r_ex.jump_target;
        if (r_ex.op == OP_SW) begin
            o_res.store_valid   = 1'b1;
            o_res.store_address = val_a + sext_imm;
            o_res.store_data    = val_b;
        end
    end
    assign o_res_push = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_vld <= 1'b0;
            r_valid  <= '0;
        end else begin
            if (load) begin
                r_ex_vld <= !i_dec_empty;
            end
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_regs[wr_addr] <= wr_data;
        end
        if (o_dec_pop) begin
            r_ex       <= i_dec;
            r_rd_a     <= r_regs[i_dec.rs];
            r_rd_b     <= r_regs[i_dec.rt];
            r_hit_a    <= r_valid[i_dec.rs];
            r_hit_b    <= r_valid[i_dec.rt];
            r_fwd_a    <= wr_en && (wr_addr == i_dec.rs);
            r_fwd_b    <= wr_en && (wr_addr == i_dec.rt);
            r_fwd_data <= wr_data;
        end
    end

    a_no_zero_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_addr != '0))
        else $error("write to register zero");

    a_fault_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ex_vld && r_ex.status != ST_DONE) |-> !wr_en)
        else $error("faulting instruction wrote a register");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ex_vld && i_res_full) |=> (r_ex_vld && $stable(r_ex)))
        else $error("execute stage changed while stalled");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dec_pop |-> (!r_ex_vld || !i_res_full))
        else $error("decode queue popped while execute stage blocked");

endmodule

`default_nettype wire

/* src/mips_subset_execute_unit.sv */
// top level of the mips subset execute unit
// Usage:
//   Input channel: drive i_instruction_word and i_current_pc with push high;
//   the request is taken at a rising edge where push is high and full is low.
//   Result channel: while empty is low the oldest result sits on the o_ ports;
//   it is taken at a rising edge where pop is high and empty is low.
//   Every request gives exactly one result, in order.
//   Path: a request passes the decode queue, then register file read,
//   then execute into result queue, each step registered.
//   Throughput: one request per cycle unless a stall holds it; register
//   file read and execute are separate registered steps, with same-cycle
//   write bypass so back-to-back dependent instructions need no stall.
//   Stalls: when pop stays low the result queue fills, the execute stage
//   holds, then the decode queue fills and full rises.
//   Reset: synchronous, active low on i_rst_n; queues empty and every
//   register reads as zero right away through its cleared valid bit.
`default_nettype none

module mips_subset_execute_unit
    import mse_pkg::*;
#(
    parameter int DEC_DEPTH = DEC_QUEUE_DEPTH,
    parameter int RES_DEPTH = RES_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] i_instruction_word,
    input  wire logic [31:0] i_current_pc,
    input  wire logic        pop,
    output logic             empty,
    output logic [1:0]       o_status,
    output logic             o_jump_taken,
    output logic [31:0]      o_jump_target,
    output logic             o_store_valid,
    output logic [31:0]      o_store_address,
    output logic [31:0]      o_store_data
);

    localparam int DEC_W = $bits(t_dec);
    localparam int RES_W = $bits(t_res);

    t_dec             dec_in;
    logic [DEC_W-1:0] dec_q;
    logic             dec_empty;
    logic             dec_pop;
    t_res             res_in;
    logic [RES_W-1:0] res_q;
    logic             res_push;
    logic             res_full;
    t_res             res_out;

    mse_front u_front (
        .i_instruction_word (i_instruction_word),
        .i_current_pc       (i_current_pc),
        .o_dec              (dec_in)
    );

    mse_queue #(
        .WIDTH (DEC_W),
        .DEPTH (DEC_DEPTH)
    ) u_dec_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (dec_in),
        .o_full  (full),
        .i_pop   (dec_pop),
        .o_rdata (dec_q),
        .o_empty (dec_empty)
    );

    mse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dec       (t_dec'(dec_q)),
        .i_dec_empty (dec_empty),
        .o_dec_pop   (dec_pop),
        .o_res       (res_in),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    mse_queue #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_q),
        .o_empty (empty)
    );

    assign res_out         = t_res'(res_q);
    assign o_status        = res_out.status;
    assign o_jump_taken    = res_out.jump_taken;
    assign o_jump_target   = res_out.jump_target;
    assign o_store_valid   = res_out.store_valid;
    assign o_store_address = res_out.store_address;
    assign o_store_data    = res_out.store_data;

endmodule

`default_nettype wire
